// ===== hdl/n6502alu_pkg.sv =====
// ----------------------------------------------------------------------------
// n6502alu_pkg
// Operation codes, flag positions and the request type shared by the
// front end, the request queue and the execute stage.
// ----------------------------------------------------------------------------
package n6502alu_pkg;

  localparam int unsigned ActCount  = 50;
  localparam int unsigned QueueDepth = 2;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] SP_RESET = 8'hFD;

  typedef enum logic [5:0] {
    ACT_ADC = 6'd0,  ACT_SBC = 6'd1,  ACT_AND = 6'd2,  ACT_ORA = 6'd3,
    ACT_EOR = 6'd4,  ACT_CMP = 6'd5,  ACT_CPX = 6'd6,  ACT_CPY = 6'd7,
    ACT_BIT = 6'd8,  ACT_ASL = 6'd9,  ACT_LSR = 6'd10, ACT_ROL = 6'd11,
    ACT_ROR = 6'd12, ACT_INC = 6'd13, ACT_DEC = 6'd14, ACT_INX = 6'd15,
    ACT_INY = 6'd16, ACT_DEX = 6'd17, ACT_DEY = 6'd18, ACT_LDA = 6'd19,
    ACT_LDX = 6'd20, ACT_LDY = 6'd21, ACT_STA = 6'd22, ACT_STX = 6'd23,
    ACT_STY = 6'd24, ACT_TAX = 6'd25, ACT_TAY = 6'd26, ACT_TXA = 6'd27,
    ACT_TSX = 6'd28, ACT_TXS = 6'd29, ACT_CLC = 6'd30, ACT_SEC = 6'd31,
    ACT_CLI = 6'd32, ACT_SEI = 6'd33, ACT_CLD = 6'd34, ACT_SED = 6'd35,
    ACT_CLV = 6'd36, ACT_BCC = 6'd37, ACT_BCS = 6'd38, ACT_BNE = 6'd39,
    ACT_BEQ = 6'd40, ACT_BPL = 6'd41, ACT_BMI = 6'd42, ACT_BVC = 6'd43,
    ACT_BVS = 6'd44, ACT_PHA = 6'd45, ACT_PHP = 6'd46, ACT_PLA = 6'd47,
    ACT_PLP = 6'd48, ACT_NOP = 6'd49
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] operand;
    logic       to_acc;
  } req_t;

endpackage

// ===== hdl/nmos6502_alu_and_registers.sv =====
// ----------------------------------------------------------------------------
// nmos6502_alu_and_registers
// Execute unit of a 6502 without decimal mode, holding A, X, Y, S and P.
//
// Input channel (in_valid/in_ready): one request per operation, carrying the
// action code, the fetched or pulled operand byte and the shift target.
// Codes above NOP run as NOP. Output channel (out_valid/out_ready): one
// result per request, in order: write byte and strobe, branch decision and
// the register file after the operation.
// A request accepted on the input channel passes the front register, the
// two-entry queue and the execute register in turn before its result shows.
// Throughput is one request per cycle while out_ready is high.
// When out_ready is low the result holds, execute stops, the queue and then
// the front register fill and in_ready drops; three more requests are taken
// behind the held result before the input stalls.
// Reset clears A, X, Y and P, sets S to 0xFD and empties the pipeline.
// ----------------------------------------------------------------------------
module nmos6502_alu_and_registers (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_action,
  input  logic [7:0] in_operand,
  input  logic       in_on_accumulator,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_write_data,
  output logic       out_write_valid,
  output logic       out_branch_taken,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_index_x_out,
  output logic [7:0] out_index_y_out,
  output logic [7:0] out_stack_ptr_out,
  output logic [7:0] out_status_out
);
  import n6502alu_pkg::*;

  logic front_valid;
  logic front_ready;
  req_t front_req;
  logic exec_valid;
  logic exec_ready;
  req_t exec_req;

  n6502alu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_operand        (in_operand),
    .in_on_accumulator (in_on_accumulator),
    .req_valid         (front_valid),
    .req_ready         (front_ready),
    .req               (front_req)
  );

  n6502alu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_req   (front_req),
    .pop_valid  (exec_valid),
    .pop_ready  (exec_ready),
    .pop_req    (exec_req)
  );

  n6502alu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (exec_valid),
    .req_ready         (exec_ready),
    .req               (exec_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_data    (out_write_data),
    .out_write_valid   (out_write_valid),
    .out_branch_taken  (out_branch_taken),
    .out_acc_out       (out_acc_out),
    .out_index_x_out   (out_index_x_out),
    .out_index_y_out   (out_index_y_out),
    .out_stack_ptr_out (out_stack_ptr_out),
    .out_status_out    (out_status_out)
  );

endmodule

// ===== hdl/n6502alu_front.sv =====
// ----------------------------------------------------------------------------
// n6502alu_front
// Accepts input requests, maps undefined codes to NOP, resolves the shift
// target and holds the classified request for the queue.
// ----------------------------------------------------------------------------
module n6502alu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [5:0]           in_action,
  input  logic [7:0]           in_operand,
  input  logic                 in_on_accumulator,
  output logic                 req_valid,
  input  logic                 req_ready,
  output n6502alu_pkg::req_t   req
);
  import n6502alu_pkg::*;

  logic valid_r;
  req_t req_r;
  req_t req_nxt;
  logic is_shift;

  assign in_ready  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    req_nxt.act     = (32'(in_action) < ActCount) ? act_t'(in_action) : ACT_NOP;
    req_nxt.operand = in_operand;
    is_shift = (req_nxt.act == ACT_ASL) || (req_nxt.act == ACT_LSR) ||
               (req_nxt.act == ACT_ROL) || (req_nxt.act == ACT_ROR);
    req_nxt.to_acc  = in_on_accumulator && is_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_r <= req_nxt;
    end
  end

endmodule

// ===== hdl/n6502alu_queue.sv =====
// ----------------------------------------------------------------------------
// n6502alu_queue
// Two-entry request queue between the front end and the execute stage.
// ----------------------------------------------------------------------------
module n6502alu_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  n6502alu_pkg::req_t   push_req,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output n6502alu_pkg::req_t   pop_req
);
  import n6502alu_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);

  req_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != Full);
  assign pop_valid  = (count_r != '0);
  assign pop_req    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QueueDepth - 1) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QueueDepth - 1) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Full) else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CntW'(1))
    else $error("queue count did not grow on push");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - CntW'(1))
    else $error("queue count did not shrink on pop");

endmodule

// ===== hdl/n6502alu_back.sv =====
// ----------------------------------------------------------------------------
// n6502alu_back
// Execute stage: holds A, X, Y, S and P, carries out one request per cycle
// while out_ready is high, and registers the result for the output channel.
// ----------------------------------------------------------------------------
module n6502alu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  n6502alu_pkg::req_t   req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_write_data,
  output logic                 out_write_valid,
  output logic                 out_branch_taken,
  output logic [7:0]           out_acc_out,
  output logic [7:0]           out_index_x_out,
  output logic [7:0]           out_index_y_out,
  output logic [7:0]           out_stack_ptr_out,
  output logic [7:0]           out_status_out
);
  import n6502alu_pkg::*;

  logic       valid_r;
  logic [7:0] a_r, x_r, y_r, s_r, p_r;
  logic [7:0] a_nxt, x_nxt, y_nxt, s_nxt, p_nxt;
  logic [7:0] wdata_r, wdata_nxt;
  logic       wvalid_r, wvalid_nxt;
  logic       taken_r, taken_nxt;
  logic       pop;

  logic [7:0] m;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_reg;
  logic [7:0] src;
  logic [7:0] shr;
  logic       cout;
  logic [7:0] nz_val;
  logic       nz_en;

  assign req_ready = !valid_r || out_ready;
  assign pop       = req_valid && req_ready;

  assign out_valid         = valid_r;
  assign out_write_data    = wdata_r;
  assign out_write_valid   = wvalid_r;
  assign out_branch_taken  = taken_r;
  assign out_acc_out       = a_r;
  assign out_index_x_out   = x_r;
  assign out_index_y_out   = y_r;
  assign out_stack_ptr_out = s_r;
  assign out_status_out    = p_r;

  always_comb begin
    m       = req.operand;
    addend  = (req.act == ACT_SBC) ? ~m : m;
    sum     = {1'b0, a_r} + {1'b0, addend} + {8'd0, p_r[FLAG_C]};
    cmp_reg = (req.act == ACT_CPX) ? x_r : ((req.act == ACT_CPY) ? y_r : a_r);
    diff    = {1'b0, cmp_reg} - {1'b0, m};
    src     = req.to_acc ? a_r : m;
    shr     = 8'h00;
    cout    = 1'b0;

    a_nxt      = a_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    s_nxt      = s_r;
    p_nxt      = p_r;
    wdata_nxt  = 8'h00;
    wvalid_nxt = 1'b0;
    taken_nxt  = 1'b0;
    nz_val     = 8'h00;
    nz_en      = 1'b0;

    unique case (req.act)
      ACT_ADC, ACT_SBC: begin
        a_nxt = sum[7:0];
        p_nxt[FLAG_C] = sum[8];
        p_nxt[FLAG_V] = ~(a_r[7] ^ addend[7]) & (a_r[7] ^ sum[7]);
        nz_val = sum[7:0]; nz_en = 1'b1;
      end
      ACT_AND: begin a_nxt = a_r & m; nz_val = a_nxt; nz_en = 1'b1; end
      ACT_ORA: begin a_nxt = a_r | m; nz_val = a_nxt; nz_en = 1'b1; end
      ACT_EOR: begin a_nxt = a_r ^ m; nz_val = a_nxt; nz_en = 1'b1; end
      ACT_CMP, ACT_CPX, ACT_CPY: begin
        nz_val = diff[7:0]; nz_en = 1'b1;
        p_nxt[FLAG_C] = ~diff[8];
      end
      ACT_BIT: begin
        p_nxt[FLAG_N] = m[7];
        p_nxt[FLAG_V] = m[6];
        p_nxt[FLAG_Z] = ((a_r & m) == 8'h00);
      end
      ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR: begin
        priority case (req.act)
          ACT_ASL: begin shr = {src[6:0], 1'b0};        cout = src[7]; end
          ACT_LSR: begin shr = {1'b0, src[7:1]};        cout = src[0]; end
          ACT_ROL: begin shr = {src[6:0], p_r[FLAG_C]}; cout = src[7]; end
          default: begin shr = {p_r[FLAG_C], src[7:1]}; cout = src[0]; end
        endcase
        p_nxt[FLAG_C] = cout;
        nz_val = shr; nz_en = 1'b1;
        if (req.to_acc) begin
          a_nxt = shr;
        end else begin
          wdata_nxt = shr; wvalid_nxt = 1'b1;
        end
      end
      ACT_INC: begin
        wdata_nxt = m + 8'd1; wvalid_nxt = 1'b1; nz_val = wdata_nxt; nz_en = 1'b1;
      end
      ACT_DEC: begin
        wdata_nxt = m - 8'd1; wvalid_nxt = 1'b1; nz_val = wdata_nxt; nz_en = 1'b1;
      end
      ACT_INX: begin x_nxt = x_r + 8'd1; nz_val = x_nxt; nz_en = 1'b1; end
      ACT_INY: begin y_nxt = y_r + 8'd1; nz_val = y_nxt; nz_en = 1'b1; end
      ACT_DEX: begin x_nxt = x_r - 8'd1; nz_val = x_nxt; nz_en = 1'b1; end
      ACT_DEY: begin y_nxt = y_r - 8'd1; nz_val = y_nxt; nz_en = 1'b1; end
      ACT_LDA: begin a_nxt = m; nz_val = m; nz_en = 1'b1; end
      ACT_LDX: begin x_nxt = m; nz_val = m; nz_en = 1'b1; end
      ACT_LDY: begin y_nxt = m; nz_val = m; nz_en = 1'b1; end
      ACT_STA: begin wdata_nxt = a_r; wvalid_nxt = 1'b1; end
      ACT_STX: begin wdata_nxt = x_r; wvalid_nxt = 1'b1; end
      ACT_STY: begin wdata_nxt = y_r; wvalid_nxt = 1'b1; end
      ACT_TAX: begin x_nxt = a_r; nz_val = a_r; nz_en = 1'b1; end
      ACT_TAY: begin y_nxt = a_r; nz_val = a_r; nz_en = 1'b1; end
      ACT_TXA: begin a_nxt = x_r; nz_val = x_r; nz_en = 1'b1; end
      ACT_TSX: begin x_nxt = s_r; nz_val = s_r; nz_en = 1'b1; end
      ACT_TXS: s_nxt = x_r;
      ACT_CLC: p_nxt[FLAG_C] = 1'b0;
      ACT_SEC: p_nxt[FLAG_C] = 1'b1;
      ACT_CLI: p_nxt[FLAG_I] = 1'b0;
      ACT_SEI: p_nxt[FLAG_I] = 1'b1;
      ACT_CLD: p_nxt[FLAG_D] = 1'b0;
      ACT_SED: p_nxt[FLAG_D] = 1'b1;
      ACT_CLV: p_nxt[FLAG_V] = 1'b0;
      ACT_BCC: taken_nxt = ~p_r[FLAG_C];
      ACT_BCS: taken_nxt =  p_r[FLAG_C];
      ACT_BNE: taken_nxt = ~p_r[FLAG_Z];
      ACT_BEQ: taken_nxt =  p_r[FLAG_Z];
      ACT_BPL: taken_nxt = ~p_r[FLAG_N];
      ACT_BMI: taken_nxt =  p_r[FLAG_N];
      ACT_BVC: taken_nxt = ~p_r[FLAG_V];
      ACT_BVS: taken_nxt =  p_r[FLAG_V];
      ACT_PHA: begin wdata_nxt = a_r; wvalid_nxt = 1'b1; s_nxt = s_r - 8'd1; end
      ACT_PHP: begin wdata_nxt = p_r; wvalid_nxt = 1'b1; s_nxt = s_r - 8'd1; end
      ACT_PLA: begin s_nxt = s_r + 8'd1; a_nxt = m; nz_val = m; nz_en = 1'b1; end
      ACT_PLP: begin s_nxt = s_r + 8'd1; p_nxt = m; end
      default: ;
    endcase

    if (nz_en) begin
      p_nxt[FLAG_N] = nz_val[7];
      p_nxt[FLAG_Z] = (nz_val == 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      a_r     <= 8'h00;
      x_r     <= 8'h00;
      y_r     <= 8'h00;
      s_r     <= SP_RESET;
      p_r     <= 8'h00;
    end else begin
      if (req_ready) begin
        valid_r <= req_valid;
      end
      if (pop) begin
        a_r <= a_nxt;
        x_r <= x_nxt;
        y_r <= y_nxt;
        s_r <= s_nxt;
        p_r <= p_nxt;
      end
    end
    if (pop) begin
      wdata_r  <= wdata_nxt;
      wvalid_r <= wvalid_nxt;
      taken_r  <= taken_nxt;
    end
  end

  a_wdata_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !wvalid_r |-> wdata_r == 8'h00)
    else $error("write data not cleared without a write");

  a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && taken_r |-> !wvalid_r)
    else $error("taken branch also requested a write");

  a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(a_r) && $stable(x_r) && $stable(y_r) && $stable(s_r) && $stable(p_r))
    else $error("register file changed without a request");

endmodule
